// ===== rtl/sbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbb_pkg: shared definitions for the separable binomial RGBA blur
// Tile geometry, arithmetic widths, pixel and tap types, line store port.
// ----------------------------------------------------------------------------
package sbb_pkg;

    // Tile and kernel geometry
    localparam int TILE_SIZE  = 64;
    localparam int TAPS       = 5;
    localparam int CENTRE     = TAPS / 2;
    localparam int STORE_ROWS = TAPS - 1;
    localparam int CNT_W      = $clog2(TILE_SIZE);
    localparam int SLOT_W     = $clog2(STORE_ROWS);

    // Pixel and arithmetic widths
    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int CHANNELS  = PIX_W / CH_W;
    localparam int WEIGHT_W  = 9;
    localparam int FRAC_W    = 8;
    localparam int PROD_W    = CH_W + WEIGHT_W;
    localparam int ACC_W     = PROD_W + $clog2(TAPS);
    localparam int OUT_POS_W = 6;
    localparam int CFG_IDX_W = $clog2(TAPS);

    localparam logic [CH_W-1:0] CH_MAX = 8'hff;

    typedef logic [PIX_W-1:0]    pixel_t;
    typedef logic [WEIGHT_W-1:0] weight_t;
    typedef logic [CNT_W-1:0]    pos_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    // Tap index 0 is the oldest pixel (left or top)
    typedef pixel_t  [TAPS-1:0]       tap_pix_t;
    typedef weight_t [TAPS-1:0]       tap_weight_t;
    typedef pixel_t  [STORE_ROWS-1:0] line_word_t;

    localparam tap_weight_t WEIGHT_RESET =
        {9'd16, 9'd64, 9'd96, 9'd64, 9'd16};

    // Line store write request
    typedef struct packed {
        logic   en;
        slot_t  bank;
        pos_t   addr;
        pixel_t data;
    } line_wr_t;

    // Position carried along the pipeline with each pixel
    typedef struct packed {
        pos_t  col;
        pos_t  row;
        slot_t slot;
        logic  emit;
        logic  last;
    } pos_meta_t;

endpackage
`default_nettype wire

// ===== rtl/sbb_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbb_if: valid/ready channels of the RGBA blur
// Input pixel channel and blurred result channel.
// ----------------------------------------------------------------------------
interface sbb_pixel_if import sbb_pkg::*; ();
    logic   valid;
    logic   ready;
    pixel_t pixel_in;
    logic   frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface sbb_result_if import sbb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    pixel_t               pixel_out;
    logic [OUT_POS_W-1:0] out_col;
    logic [OUT_POS_W-1:0] out_row;
    logic                 tile_last;

    modport source (output valid, output pixel_out, output out_col, output out_row,
                    output tile_last, input ready);
    modport sink   (input valid, input pixel_out, input out_col, input out_row,
                    input tile_last, output ready);
endinterface
`default_nettype wire

// ===== rtl/sbb_line_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbb_line_store: four banks of horizontal results, one bank per row slot
// All banks read at one column per cycle, one bank written per cycle.
// ----------------------------------------------------------------------------
module sbb_line_store import sbb_pkg::*; (
    input  logic       clk,
    input  logic       rd_en,
    input  pos_t       rd_addr,
    input  line_wr_t   wr,
    output line_word_t rd_data
);

    // One synchronous bank per row slot
    for (genvar b = 0; b < STORE_ROWS; b++)
    begin : g_bank
        pixel_t bank_mem [TILE_SIZE];
        pixel_t rd_word_reg;

        always_ff @(posedge clk)
        begin
            if (wr.en && (wr.bank == SLOT_W'(b)))
            begin
                bank_mem[wr.addr] <= wr.data;
            end
            if (rd_en)
            begin
                rd_word_reg <= bank_mem[rd_addr];
            end
        end

        assign rd_data[b] = rd_word_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/sbb_tap_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbb_tap_filter: one 5-tap pass over four 8-bit channels
// Registers the 20 channel-by-weight products, then sums, drops the
// fraction and clamps each channel at 255.
// ----------------------------------------------------------------------------
module sbb_tap_filter import sbb_pkg::*; (
    input  logic        clk,
    input  logic        load,
    input  tap_pix_t    taps,
    input  tap_weight_t weights,
    output pixel_t      result
);

    logic [PROD_W-1:0] prod_reg [CHANNELS][TAPS];

    // Capture products, one lane per channel and tap
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                for (int t = 0; t < TAPS; t++)
                begin
                    prod_reg[ch][t] <= PROD_W'(taps[t][ch*CH_W +: CH_W])
                                     * PROD_W'(weights[t]);
                end
            end
        end
    end

    // Sum, truncate the fraction, saturate
    always_comb
    begin
        logic [ACC_W-1:0]        acc;
        logic [ACC_W-FRAC_W-1:0] scaled;
        result = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            acc = '0;
            for (int t = 0; t < TAPS; t++)
            begin
                acc = acc + ACC_W'(prod_reg[ch][t]);
            end
            scaled = acc[ACC_W-1:FRAC_W];
            if (scaled > (ACC_W-FRAC_W)'(CH_MAX))
            begin
                result[ch*CH_W +: CH_W] = CH_MAX;
            end
            else
            begin
                result[ch*CH_W +: CH_W] = scaled[CH_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/separable_binomial_blur_rgba_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// separable_binomial_blur_rgba_unit: 5x5 separable blur of RGBA tiles
// Horizontal pass over a pixel window, vertical pass over four banked
// line stores of horizontal results; interior pixels only.
//
//   channel   role     beat contents
//   pix       sink     pixel_in, frame_start
//   blur      source   pixel_out, out_col, out_row, tile_last
//   cfg_*     write    cfg_index selects tap weight, cfg_data is Q1.8 weight
//
// One pixel is accepted every cycle while pix.ready is high; a result passes
// through the line store read with horizontal products, the vertical tap
// register, the vertical products and the output register.
// The registered read of the line store banks at the current column sets
// the pipeline: each column entry is read and rewritten once per row.
// Reset clears counters and window and loads the default weights; the line
// store needs no clearing, its entries are always written before they are used.
// A stalled output fills the three inner stages before pix.ready drops.
// ----------------------------------------------------------------------------
module separable_binomial_blur_rgba_unit import sbb_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  weight_t              cfg_data,
    sbb_pixel_if.sink            pix,
    sbb_result_if.source         blur
);

    tap_weight_t weight_reg;
    pos_t        col_cnt_reg;
    pos_t        row_cnt_reg;
    line_word_t  win_reg;

    logic      va_reg, vb_reg, vc_reg, out_valid_reg;
    pos_meta_t meta_a_reg, meta_b_reg, meta_c_reg;
    tap_pix_t  colpix_b_reg;

    pixel_t               out_pixel_reg;
    logic [OUT_POS_W-1:0] out_col_reg;
    logic [OUT_POS_W-1:0] out_row_reg;
    logic                 out_last_reg;

    pos_t       col_cur, row_cur, col_next, row_next;
    logic       col_last, row_last, h_hit, accept;
    pos_meta_t  meta_now;
    tap_pix_t   taps_now, colpix_next;
    line_word_t line_rd;
    line_wr_t   line_wr;
    pixel_t     h_result, v_result;

    logic out_free, c_free, b_free, a_free;
    logic adv_a, adv_b, adv_c;

    // Stall chain: a stage moves when the one after it is empty or moving
    assign out_free = !out_valid_reg || blur.ready;
    assign adv_c    = vc_reg && out_free;
    assign c_free   = !vc_reg || out_free;
    assign adv_b    = vb_reg && c_free;
    assign b_free   = !vb_reg || c_free;
    assign adv_a    = va_reg && b_free;
    assign a_free   = !va_reg || b_free;

    assign pix.ready = a_free;
    assign accept    = pix.valid && a_free;

    // Position of the incoming pixel
    always_comb
    begin
        col_cur  = pix.frame_start ? '0 : col_cnt_reg;
        row_cur  = pix.frame_start ? '0 : row_cnt_reg;
        col_last = (col_cur == pos_t'(TILE_SIZE - 1));
        row_last = (row_cur == pos_t'(TILE_SIZE - 1));
        col_next = col_last ? '0 : col_cur + 1'b1;
        row_next = row_cur;
        if (col_last)
        begin
            row_next = row_last ? '0 : row_cur + 1'b1;
        end
        h_hit         = (col_cur >= pos_t'(TAPS - 1));
        meta_now.col  = col_cur - pos_t'(CENTRE);
        meta_now.row  = row_cur - pos_t'(CENTRE);
        meta_now.slot = row_cur[SLOT_W-1:0];
        meta_now.emit = (row_cur >= pos_t'(TAPS - 1));
        meta_now.last = col_last && row_last;
        taps_now      = {pix.pixel_in, win_reg};
    end

    // Weights, counters and pixel window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg  <= WEIGHT_RESET;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            win_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en && (cfg_index < CFG_IDX_W'(TAPS)))
            begin
                weight_reg[cfg_index] <= cfg_data;
            end
            if (accept)
            begin
                col_cnt_reg <= col_next;
                row_cnt_reg <= row_next;
                win_reg     <= {pix.pixel_in, win_reg[STORE_ROWS-1:1]};
            end
        end
    end

    // Horizontal pass, products captured on accept once the window is full
    sbb_tap_filter u_h_filter (
        .clk     (clk),
        .load    (accept && h_hit),
        .taps    (taps_now),
        .weights (weight_reg),
        .result  (h_result)
    );

    // Line store: read the four stored rows at this column on accept once the
    // window is full, write the new horizontal result when stage A moves on
    always_comb
    begin
        line_wr.en   = adv_a;
        line_wr.bank = meta_a_reg.slot;
        line_wr.addr = meta_a_reg.col;
        line_wr.data = h_result;
    end

    sbb_line_store u_line_store (
        .clk     (clk),
        .rd_en   (accept && h_hit),
        .rd_addr (meta_now.col),
        .wr      (line_wr),
        .rd_data (line_rd)
    );

    // Order the vertical taps oldest row first
    always_comb
    begin
        for (int i = 0; i < STORE_ROWS; i++)
        begin
            colpix_next[i] = line_rd[meta_a_reg.slot + SLOT_W'(i)];
        end
        colpix_next[TAPS-1] = h_result;
    end

    // Stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                va_reg <= h_hit;
            end
            else if (adv_a)
            begin
                va_reg <= 1'b0;
            end
            if (adv_a)
            begin
                vb_reg <= meta_a_reg.emit;
            end
            else if (adv_b)
            begin
                vb_reg <= 1'b0;
            end
            if (adv_b)
            begin
                vc_reg <= 1'b1;
            end
            else if (adv_c)
            begin
                vc_reg <= 1'b0;
            end
            if (adv_c)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (blur.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meta_a_reg <= meta_now;
        end
        if (adv_a)
        begin
            meta_b_reg   <= meta_a_reg;
            colpix_b_reg <= colpix_next;
        end
        if (adv_b)
        begin
            meta_c_reg <= meta_b_reg;
        end
        if (adv_c)
        begin
            out_pixel_reg <= v_result;
            out_col_reg   <= OUT_POS_W'(meta_c_reg.col);
            out_row_reg   <= OUT_POS_W'(meta_c_reg.row);
            out_last_reg  <= meta_c_reg.last;
        end
    end

    // Vertical pass, products captured when stage B moves on
    sbb_tap_filter u_v_filter (
        .clk     (clk),
        .load    (adv_b),
        .taps    (colpix_b_reg),
        .weights (weight_reg),
        .result  (v_result)
    );

    assign blur.valid     = out_valid_reg;
    assign blur.pixel_out = out_pixel_reg;
    assign blur.out_col   = out_col_reg;
    assign blur.out_row   = out_row_reg;
    assign blur.tile_last = out_last_reg;

    // A read and a write of the line store never meet at one column
    a_line_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && h_hit && line_wr.en) |-> (meta_now.col != line_wr.addr))
        else $error("line store read and write at the same column");

    // The last interior pixel sits at the far interior corner
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (blur.valid && blur.tile_last) |->
        ((blur.out_col == OUT_POS_W'(TILE_SIZE - 1 - CENTRE)) &&
         (blur.out_row == OUT_POS_W'(TILE_SIZE - 1 - CENTRE))))
        else $error("tile_last away from the interior corner");

    // A blocked item in stage B stays put with its position
    a_hold_b: assert property (@(posedge clk) disable iff (!rst_n)
        (vb_reg && !c_free) |=> (vb_reg && $stable(meta_b_reg)))
        else $error("stage B item lost under stall");

endmodule
`default_nettype wire
